/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/spm_pkg.sv */
// Types and constants of the stereo peak and RMS level meter.
package spm_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int MAX_BLOCK_DEF = 4096;

  localparam int MAG_W  = SAMPLE_BITS;       // magnitude, up to 2^(SAMPLE_BITS-1)
  localparam int PEAK_W = SAMPLE_BITS - 1;   // saturated magnitude
  localparam int PROD_W = 2 * MAG_W;
  localparam int GAIN_W = 16;
  localparam int AGE_W  = 8;

  localparam logic [PEAK_W-1:0] PEAK_MAX = '1;
  localparam logic [AGE_W-1:0]  AGE_MAX  = '1;

  localparam logic [AGE_W-1:0]  HOLD_BLOCKS_RST = 8'd40;
  localparam logic [GAIN_W-1:0] DECAY_GAIN_RST  = 16'd62259;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN  = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_in_block;
  } in_item_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak_left;
    logic [PEAK_W-1:0] peak_right;
    logic [PEAK_W-1:0] rms_left;
    logic [PEAK_W-1:0] rms_right;
    logic [PEAK_W-1:0] hold_left;
    logic [PEAK_W-1:0] hold_right;
  } out_item_t;

endpackage

/* sv/spm_mul.sv */
// Shared unsigned multiplier with a registered product.
module spm_mul
  import spm_pkg::*;
(
  input  logic              clk,
  input  logic [MAG_W-1:0]  op_a,
  input  logic [MAG_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

/* sv/spm_root.sv */
// Iterative unit: restoring division of a sum by a count, then integer square root.
module spm_root
  import spm_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [2*SAMPLE_BITS+$clog2(MAX_BLOCK)-1:0] dividend,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]         divisor,
  output logic                                   done,
  output logic [PEAK_W-1:0]                      root
);

  localparam int SUM_W  = 2 * SAMPLE_BITS + $clog2(MAX_BLOCK);
  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int QUO_W  = 2 * SAMPLE_BITS - 1;   // a mean of squares never exceeds this
  localparam int RAD_W  = 2 * SAMPLE_BITS;
  localparam int SRT_W  = SAMPLE_BITS;
  localparam int SREM_W = SAMPLE_BITS + 2;
  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_DIV  = 3'b010,
    R_SQRT = 3'b100
  } rstate_t;

  rstate_t             rstate;
  logic [SUM_W-1:0]    dq;
  logic [CNT_W-1:0]    drem;
  logic [CNT_W-1:0]    dvsr;
  logic [STEP_W-1:0]   step;
  logic [RAD_W-1:0]    sx;
  logic [SREM_W-1:0]   srem;
  logic [SRT_W-1:0]    sroot;

  logic [CNT_W:0]      drem_sh;
  logic                div_ge;
  logic [CNT_W-1:0]    drem_next;
  logic [SUM_W-1:0]    dq_next;
  logic [SREM_W+1:0]   srem_sh;
  logic [SREM_W+1:0]   trial;
  logic                sq_ge;
  logic [SREM_W-1:0]   srem_next;
  logic [SRT_W-1:0]    sroot_next;

  // One quotient bit per cycle.
  assign drem_sh   = {drem, dq[SUM_W-1]};
  assign div_ge    = drem_sh >= {1'b0, dvsr};
  assign drem_next = div_ge ? CNT_W'(drem_sh - {1'b0, dvsr}) : drem_sh[CNT_W-1:0];
  assign dq_next   = {dq[SUM_W-2:0], div_ge};

  // One root bit per cycle, two radicand bits consumed.
  assign srem_sh    = {srem, sx[RAD_W-1 -: 2]};
  assign trial      = (SREM_W + 2)'({sroot, 2'b01});
  assign sq_ge      = srem_sh >= trial;
  assign srem_next  = sq_ge ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
  assign sroot_next = {sroot[SRT_W-2:0], sq_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      rstate <= R_IDLE;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      case (rstate)
        R_IDLE: begin
          if (start) begin
            rstate <= R_DIV;
            step   <= '0;
          end
        end
        R_DIV: begin
          if (step == STEP_W'(SUM_W - 1)) begin
            rstate <= R_SQRT;
            step   <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        R_SQRT: begin
          if (step == STEP_W'(SRT_W - 1)) begin
            rstate <= R_IDLE;
            done   <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: begin
          rstate <= R_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (rstate)
      R_IDLE: begin
        if (start) begin
          dq   <= dividend;
          dvsr <= divisor;
          drem <= '0;
        end
      end
      R_DIV: begin
        dq   <= dq_next;
        drem <= drem_next;
        sx    <= RAD_W'(dq_next[QUO_W-1:0]);
        srem  <= '0;
        sroot <= '0;
      end
      R_SQRT: begin
        sx    <= {sx[RAD_W-3:0], 2'b00};
        srem  <= srem_next;
        sroot <= sroot_next;
        // The root can reach 2^(SAMPLE_BITS-1) only for the most negative sample.
        root  <= sroot_next[SRT_W-1] ? PEAK_MAX : sroot_next[PEAK_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/stereo_peak_rms_meter.sv */
// Top level of the stereo peak and RMS level meter with shared peak hold.
// Usage:
// - Input channel in_valid/in_ready/in_data carries one stereo sample pair per
//   request, signed, with last_in_block marking the final pair of a block.
//   A block also closes by itself on its MAX_BLOCK-th pair.
// - Output channel out_valid/out_ready/out_data carries one result per block:
//   block peaks, RMS per channel and the held peaks after this block.
// - Configuration: cfg_write with cfg_addr selects hold_blocks (index 0) or
//   decay_gain (index 1); write only while the block is idle.
// Timing: a pair that does not close a block keeps in_ready low while it is
// squared and summed (S_SQ_L, S_SQ_R, S_ACC_R), so such pairs are never taken
// back to back. After a closing pair the next request waits for both RMS roots,
// the hold update and, when the held peaks decay, the decay products; the result
// turns valid as in_ready rises again. Most of this wait is spent in the
// bit-serial divide and square root unit, which runs once per channel. The
// shared multiplier forms the squares and the decay products.
// Reset clears all block accumulators, held peaks and the hold age, and loads
// hold_blocks = 40 and decay_gain = 62259. A finished result sits in an output
// register; while the receiver stalls, the block still accepts and sums the
// next pairs and only waits if a second block ends before the first result
// has been taken.
`include "assert_macros.svh"

module stereo_peak_rms_meter
  import spm_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_BLOCK);
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SQ_L  = 11'b00000000010,
    S_SQ_R  = 11'b00000000100,
    S_ACC_R = 11'b00000001000,
    S_RMS_L = 11'b00000010000,
    S_RMS_R = 11'b00000100000,
    S_HOLD  = 11'b00001000000,
    S_DEC_L = 11'b00010000000,
    S_DEC_R = 11'b00100000000,
    S_DEC_W = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t              state;
  logic [AGE_W-1:0]    hold_blocks;
  logic [GAIN_W-1:0]   decay_gain;

  logic [MAG_W-1:0]    mag_left;
  logic [MAG_W-1:0]    mag_right;
  logic                last_pair;
  logic [PEAK_W-1:0]   run_peak_left;
  logic [PEAK_W-1:0]   run_peak_right;
  logic [SUM_W-1:0]    sum_sq_left;
  logic [SUM_W-1:0]    sum_sq_right;
  logic [CNT_W-1:0]    pair_count;
  logic [PEAK_W-1:0]   held_left;
  logic [PEAK_W-1:0]   held_right;
  logic [AGE_W-1:0]    hold_age;
  logic [PEAK_W-1:0]   rms_left;
  logic [PEAK_W-1:0]   rms_right;
  logic                decay_now;

  logic                in_accept;
  logic [MAG_W-1:0]    mag_in_left;
  logic [MAG_W-1:0]    mag_in_right;
  logic [PEAK_W-1:0]   sat_in_left;
  logic [PEAK_W-1:0]   sat_in_right;

  logic [MAG_W-1:0]    mul_a;
  logic [MAG_W-1:0]    mul_b;
  logic [PROD_W-1:0]   prod;
  logic [PEAK_W-1:0]   prod_decayed;

  logic                root_start;
  logic [SUM_W-1:0]    root_dividend;
  logic                root_done;
  logic [PEAK_W-1:0]   root;

  logic                block_end;
  logic                raise_left;
  logic                raise_right;
  logic [AGE_W-1:0]    age_base;
  logic [AGE_W-1:0]    age_next;
  logic                out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Two's-complement magnitude; the most negative sample gives 2^(SAMPLE_BITS-1),
  // which is squared exactly but saturates for the peaks.
  assign mag_in_left  = in_data.left_sample[SAMPLE_BITS-1]
                        ? MAG_W'(~in_data.left_sample + 1'b1)
                        : MAG_W'(in_data.left_sample);
  assign mag_in_right = in_data.right_sample[SAMPLE_BITS-1]
                        ? MAG_W'(~in_data.right_sample + 1'b1)
                        : MAG_W'(in_data.right_sample);
  assign sat_in_left  = mag_in_left[MAG_W-1]  ? PEAK_MAX : mag_in_left[PEAK_W-1:0];
  assign sat_in_right = mag_in_right[MAG_W-1] ? PEAK_MAX : mag_in_right[PEAK_W-1:0];

  // Operand selection for the shared multiplier: squares of the pair, or the
  // held peaks times the decay gain.
  always_comb begin
    mul_a = mag_left;
    mul_b = mag_left;
    case (state)
      S_SQ_L: begin
        mul_a = mag_left;
        mul_b = mag_left;
      end
      S_SQ_R: begin
        mul_a = mag_right;
        mul_b = mag_right;
      end
      S_DEC_L: begin
        mul_a = MAG_W'(held_left);
        mul_b = MAG_W'(decay_gain);
      end
      S_DEC_R: begin
        mul_a = MAG_W'(held_right);
        mul_b = MAG_W'(decay_gain);
      end
      default: begin
        mul_a = mag_left;
        mul_b = mag_left;
      end
    endcase
  end

  assign prod_decayed = prod[GAIN_W +: PEAK_W];

  spm_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // The left root starts as the block closes, the right one as the left ends.
  assign block_end     = last_pair || (pair_count == CNT_W'(MAX_BLOCK));
  assign root_start    = ((state == S_ACC_R) && block_end) ||
                         ((state == S_RMS_L) && root_done);
  assign root_dividend = (state == S_ACC_R) ? sum_sq_left : sum_sq_right;

  spm_root #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .dividend (root_dividend),
    .divisor  (pair_count),
    .done     (root_done),
    .root     (root)
  );

  // Hold update: a larger block peak raises the held peak and restarts the
  // shared age, which then counts this block and saturates.
  assign raise_left  = run_peak_left > held_left;
  assign raise_right = run_peak_right > held_right;
  assign age_base    = (raise_left || raise_right) ? '0 : hold_age;
  assign age_next    = (age_base == AGE_MAX) ? AGE_MAX : age_base + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      hold_blocks    <= HOLD_BLOCKS_RST;
      decay_gain     <= DECAY_GAIN_RST;
      run_peak_left  <= '0;
      run_peak_right <= '0;
      sum_sq_left    <= '0;
      sum_sq_right   <= '0;
      pair_count     <= '0;
      held_left      <= '0;
      held_right     <= '0;
      hold_age       <= '0;
      decay_now      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_addr)
          REG_HOLD_BLOCKS: hold_blocks <= cfg_wdata[AGE_W-1:0];
          REG_DECAY_GAIN:  decay_gain  <= cfg_wdata[GAIN_W-1:0];
          default: begin
          end
        endcase
      end

      // A new result replaces a taken one in the same cycle.
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (sat_in_left > run_peak_left) begin
              run_peak_left <= sat_in_left;
            end
            if (sat_in_right > run_peak_right) begin
              run_peak_right <= sat_in_right;
            end
            pair_count <= pair_count + 1'b1;
            state      <= S_SQ_L;
          end
        end
        S_SQ_L: begin
          state <= S_SQ_R;
        end
        S_SQ_R: begin
          sum_sq_left <= sum_sq_left + SUM_W'(prod);
          state       <= S_ACC_R;
        end
        S_ACC_R: begin
          sum_sq_right <= sum_sq_right + SUM_W'(prod);
          state        <= block_end ? S_RMS_L : S_IDLE;
        end
        S_RMS_L: begin
          if (root_done) begin
            state <= S_RMS_R;
          end
        end
        S_RMS_R: begin
          if (root_done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (raise_left) begin
            held_left <= run_peak_left;
          end
          if (raise_right) begin
            held_right <= run_peak_right;
          end
          hold_age  <= age_next;
          decay_now <= age_next > hold_blocks;
          state     <= (age_next > hold_blocks) ? S_DEC_L : S_OUT;
        end
        S_DEC_L: begin
          state <= S_DEC_R;
        end
        S_DEC_R: begin
          held_left <= prod_decayed;
          state     <= S_DEC_W;
        end
        S_DEC_W: begin
          held_right <= prod_decayed;
          state      <= S_OUT;
        end
        S_OUT: begin
          // Waits here only if the previous result has not yet been taken.
          if (out_free) begin
            run_peak_left  <= '0;
            run_peak_right <= '0;
            sum_sq_left    <= '0;
            sum_sq_right   <= '0;
            pair_count     <= '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers. The output register only changes when a new result
  // is loaded, so a stalled result stays intact.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mag_left  <= mag_in_left;
      mag_right <= mag_in_right;
      last_pair <= in_data.last_in_block;
    end
    if ((state == S_RMS_L) && root_done) begin
      rms_left <= root;
    end
    if ((state == S_RMS_R) && root_done) begin
      rms_right <= root;
    end
    if ((state == S_OUT) && out_free) begin
      out_data.peak_left  <= run_peak_left;
      out_data.peak_right <= run_peak_right;
      out_data.rms_left   <= rms_left;
      out_data.rms_right  <= rms_right;
      out_data.hold_left  <= held_left;
      out_data.hold_right <= held_right;
    end
  end

  // The divide and root unit reports only while the sequencer waits for it.
  `ASSERT_SAME(a_root_done_expected, root_done,
               (state == S_RMS_L) || (state == S_RMS_R),
               "root unit finished outside an RMS state")

  // A result is only formed for a block with at least one pair.
  `ASSERT_SAME(a_block_nonempty, state == S_OUT, pair_count != '0,
               "result stage reached with an empty block")

  // Without decay the hold update never lowers a held peak.
  `ASSERT_NEXT(a_hold_no_drop, (state == S_HOLD) && !(age_next > hold_blocks),
               (held_left >= $past(held_left)) && (held_right >= $past(held_right)),
               "held peak dropped without decay")

  // Decay is entered exactly when the hold stage decided it.
  `ASSERT_SAME(a_decay_path, state == S_DEC_L, decay_now,
               "decay sequence without a decay decision")

endmodule
